// ----- rtl/gregorian_to_persian_date_unit_macros.svh -----
// Assertion macros for the Gregorian to Persian date unit.
`ifndef GREGORIAN_TO_PERSIAN_DATE_UNIT_MACROS_SVH
`define GREGORIAN_TO_PERSIAN_DATE_UNIT_MACROS_SVH

// Property checked on every rising edge of i_clk, off while i_rst_n is low.
`define GTP_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen.
`define GTP_ASSERT_NEVER(lbl, cond, msg) \
    `GTP_ASSERT_PROP(lbl, !(cond), msg)

`endif

// ----- rtl/gtp_pkg.sv -----
// Types, constants and the month table shared by the date conversion pipeline.
`default_nettype none

package gtp_pkg;

    localparam logic [11:0] YearMin   = 12'd622;
    localparam logic [11:0] BaseOld   = 12'd621;
    localparam logic [11:0] BaseNew   = 12'd1600;
    localparam logic [11:0] JyNew     = 12'd979;
    localparam logic [19:0] DayOffset = 20'd80;
    localparam logic [13:0] Days33    = 14'd12053;
    localparam logic [10:0] Days4     = 11'd1461;
    localparam logic [8:0]  DaysYear  = 9'd365;
    localparam logic [8:0]  FirstHalf = 9'd186;

    // Reciprocals for the constant divisions: x / d = (x * m) >> s.
    localparam logic [12:0] Recip100  = 13'd5243;
    localparam int unsigned Shift100  = 19;
    localparam logic [11:0] Recip400  = 12'd2622;
    localparam int unsigned Shift400  = 20;
    localparam logic [20:0] Recip33   = 21'd1425360;
    localparam int unsigned Shift33   = 34;

    typedef struct packed {
        logic        bad;
        logic [11:0] jy;
        logic [19:0] days;
    } t_count;

    typedef struct packed {
        logic        bad;
        logic [11:0] jy;
        logic [10:0] days;
    } t_cyc;

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] res;
        unique case (month)
            4'd1:    res = 9'd0;
            4'd2:    res = 9'd31;
            4'd3:    res = 9'd59;
            4'd4:    res = 9'd90;
            4'd5:    res = 9'd120;
            4'd6:    res = 9'd151;
            4'd7:    res = 9'd181;
            4'd8:    res = 9'd212;
            4'd9:    res = 9'd243;
            4'd10:   res = 9'd273;
            4'd11:   res = 9'd304;
            4'd12:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gtp_count.sv -----
// Day-count front end: base selection, leap corrections and the day number.
`default_nettype none

module gtp_count
    import gtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    output logic             o_rdy,
    input  wire logic [11:0] i_year,
    input  wire logic [3:0]  i_month,
    input  wire logic [4:0]  i_day,
    output logic             o_vld,
    input  wire logic        i_rdy,
    output t_count           o_data
);

    logic [2:0] r_vld;
    logic [2:0] stg_rdy;

    assign stg_rdy[2] = !r_vld[2] || i_rdy;
    assign stg_rdy[1] = !r_vld[1] || stg_rdy[2];
    assign stg_rdy[0] = !r_vld[0] || stg_rdy[1];
    assign o_rdy      = stg_rdy[0];
    assign o_vld      = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_vld;
            if (stg_rdy[1]) r_vld[1] <= r_vld[0];
            if (stg_rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Stage 0: clamp, base and year offset
    logic        n_s0_bad;
    logic [11:0] year_c;
    logic        old_base;
    logic [11:0] n_s0_gyo;
    logic [11:0] n_s0_jy;
    logic [11:0] n_s0_y2;
    logic [8:0]  n_s0_dsum;

    logic        r_s0_bad;
    logic [11:0] r_s0_gyo;
    logic [11:0] r_s0_jy;
    logic [11:0] r_s0_y2;
    logic [8:0]  r_s0_dsum;

    always_comb begin
        n_s0_bad  = (i_month == 4'd0) || (i_month > 4'd12);
        year_c    = (i_year < YearMin) ? YearMin : i_year;
        old_base  = (year_c <= BaseNew);
        n_s0_gyo  = old_base ? (year_c - BaseOld) : (year_c - BaseNew);
        n_s0_jy   = old_base ? 12'd0 : JyNew;
        n_s0_y2   = (i_month > 4'd2) ? (n_s0_gyo + 12'd1) : n_s0_gyo;
        n_s0_dsum = month_start(i_month) + 9'(i_day);
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_s0_bad  <= n_s0_bad;
            r_s0_gyo  <= n_s0_gyo;
            r_s0_jy   <= n_s0_jy;
            r_s0_y2   <= n_s0_y2;
            r_s0_dsum <= n_s0_dsum;
        end
    end

    // Stage 1: year days and leap terms
    logic [20:0] mul365;
    logic [24:0] mul100;
    logic [23:0] mul400;

    logic        r_s1_bad;
    logic [11:0] r_s1_jy;
    logic [8:0]  r_s1_dsum;
    logic [19:0] r_s1_prod;
    logic [9:0]  r_s1_q4;
    logic [5:0]  r_s1_q100;
    logic [3:0]  r_s1_q400;

    assign mul365 = 21'(r_s0_gyo) * 21'(DaysYear);
    assign mul100 = 25'(r_s0_y2 + 12'd99) * 25'(Recip100);
    assign mul400 = 24'(r_s0_y2 + 12'd399) * 24'(Recip400);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_s1_bad  <= r_s0_bad;
            r_s1_jy   <= r_s0_jy;
            r_s1_dsum <= r_s0_dsum;
            r_s1_prod <= mul365[19:0];
            r_s1_q4   <= 10'((r_s0_y2 + 12'd3) >> 2);
            r_s1_q100 <= 6'(mul100 >> Shift100);
            r_s1_q400 <= 4'(mul400 >> Shift400);
        end
    end

    // Stage 2: day number
    t_count r_s2;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r_s2.bad  <= r_s1_bad;
            r_s2.jy   <= r_s1_jy;
            r_s2.days <= r_s1_prod + 20'(r_s1_q4) + 20'(r_s1_q400) + 20'(r_s1_dsum)
                         - 20'(r_s1_q100) - DayOffset;
        end
    end

    assign o_data = r_s2;

endmodule

`default_nettype wire

// ----- rtl/gtp_cycle.sv -----
// Cycle reduction: 33-year and 4-year cycles taken out of the day number.
`default_nettype none

module gtp_cycle
    import gtp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_vld,
    output logic        o_rdy,
    input  wire t_count i_data,
    output logic        o_vld,
    input  wire logic   i_rdy,
    output t_cyc        o_data
);

    logic [3:0] r_vld;
    logic [3:0] stg_rdy;

    assign stg_rdy[3] = !r_vld[3] || i_rdy;
    assign stg_rdy[2] = !r_vld[2] || stg_rdy[3];
    assign stg_rdy[1] = !r_vld[1] || stg_rdy[2];
    assign stg_rdy[0] = !r_vld[0] || stg_rdy[1];
    assign o_rdy      = stg_rdy[0];
    assign o_vld      = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_vld;
            if (stg_rdy[1]) r_vld[1] <= r_vld[0];
            if (stg_rdy[2]) r_vld[2] <= r_vld[1];
            if (stg_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Stage A: quotient estimate, low by at most one
    logic [40:0] mul33;
    t_count      r_a;
    logic [6:0]  r_a_q;

    assign mul33 = 41'(i_data.days) * 41'(Recip33);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_a   <= i_data;
            r_a_q <= 7'(mul33 >> Shift33);
        end
    end

    // Stage B: remainder from the estimate
    logic [19:0] sub33;
    logic        r_b_bad;
    logic [11:0] r_b_jy;
    logic [14:0] r_b_rem;

    assign sub33 = 20'(r_a_q) * 20'(Days33);

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_b_bad <= r_a.bad;
            r_b_jy  <= r_a.jy + 12'(12'(r_a_q) * 12'd33);
            r_b_rem <= 15'(r_a.days - sub33);
        end
    end

    // Stage C: correction of the estimate
    logic        r_c_bad;
    logic [11:0] r_c_jy;
    logic [13:0] r_c_rem;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r_c_bad <= r_b_bad;
            if (r_b_rem >= 15'(Days33)) begin
                r_c_jy  <= r_b_jy + 12'd33;
                r_c_rem <= 14'(r_b_rem - 15'(Days33));
            end else begin
                r_c_jy  <= r_b_jy;
                r_c_rem <= 14'(r_b_rem);
            end
        end
    end

    // Stage D: 4-year cycles, quotient 0..8 by parallel compares
    logic [3:0] q4y;
    t_cyc       r_d;

    always_comb begin
        q4y = 4'd0;
        for (int k = 1; k <= 8; k++) begin
            if (r_c_rem >= 14'(k * 1461)) q4y = 4'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r_d.bad  <= r_c_bad;
            r_d.jy   <= r_c_jy + 12'({q4y, 2'b00});
            r_d.days <= 11'(r_c_rem - 14'(14'(q4y) * 14'(Days4)));
        end
    end

    assign o_data = r_d;

endmodule

`default_nettype wire

// ----- rtl/gtp_split.sv -----
// Year, month and day split of the day within a 4-year cycle.
`default_nettype none

module gtp_split
    import gtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    output logic             o_rdy,
    input  wire t_cyc        i_data,
    output logic             o_vld,
    input  wire logic        i_rdy,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day,
    output logic             o_bad
);

    logic [1:0] r_vld;
    logic [1:0] stg_rdy;

    assign stg_rdy[1] = !r_vld[1] || i_rdy;
    assign stg_rdy[0] = !r_vld[0] || stg_rdy[1];
    assign o_rdy      = stg_rdy[0];
    assign o_vld      = r_vld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_vld;
            if (stg_rdy[1]) r_vld[1] <= r_vld[0];
        end
    end

    // Stage A: year inside the 4-year cycle
    logic [10:0] dm1;
    logic [1:0]  qy;
    logic [8:0]  n_a_rem;
    logic [11:0] n_a_jy;

    logic        r_a_bad;
    logic [11:0] r_a_jy;
    logic [8:0]  r_a_rem;

    always_comb begin
        dm1 = i_data.days - 11'd1;
        qy  = 2'd0;
        if (i_data.days > 11'(DaysYear)) begin
            if (dm1 >= 11'd1095)     qy = 2'd3;
            else if (dm1 >= 11'd730) qy = 2'd2;
            else                     qy = 2'd1;
            n_a_rem = 9'(dm1 - 11'(11'(qy) * 11'(DaysYear)));
        end else begin
            n_a_rem = 9'(i_data.days);
        end
        n_a_jy = i_data.jy + 12'(qy);
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_a_bad <= i_data.bad;
            r_a_jy  <= n_a_jy;
            r_a_rem <= n_a_rem;
        end
    end

    // Stage B: month and day; zero fields on a bad month
    logic [8:0] tail;
    logic [2:0] qm;
    logic [3:0] n_month;
    logic [4:0] n_day;

    always_comb begin
        tail = r_a_rem - FirstHalf;
        qm   = 3'd0;
        if (r_a_rem < FirstHalf) begin
            for (int k = 1; k <= 5; k++) begin
                if (r_a_rem >= 9'(k * 31)) qm = 3'(k);
            end
            n_month = 4'd1 + 4'(qm);
            n_day   = 5'(9'd1 + r_a_rem - 9'(9'(qm) * 9'd31));
        end else begin
            for (int k = 1; k <= 5; k++) begin
                if (tail >= 9'(k * 30)) qm = 3'(k);
            end
            n_month = 4'd7 + 4'(qm);
            n_day   = 5'(9'd1 + tail - 9'(9'(qm) * 9'd30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            o_bad   <= r_a_bad;
            o_year  <= r_a_bad ? 12'd0 : r_a_jy;
            o_month <= r_a_bad ? 4'd0 : n_month;
            o_day   <= r_a_bad ? 5'd0 : n_day;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gregorian_to_persian_date_unit.sv -----
// Top level of the Gregorian to Persian (Jalali) date converter.
//
//  Channel  Dir  tdata (low bit up)                     tuser
//  s_axis   in   year[11:0] month[15:12] day[20:16]     -
//  m_axis   out  year[11:0] month[15:12] day[20:16]     bad_month
//
//  Nine register stages: three for the day count, four for the 33-year and
//  4-year cycle reduction, two for the year and month split.
//  One item per cycle while m_axis is not stalled.
//  A stage takes a new item when it is empty or its item moves on, so a stall
//  on m_axis fills bubbles first and loses nothing.
//  Reset clears all valid bits; payload registers are not reset.
`default_nettype none
`include "gregorian_to_persian_date_unit_macros.svh"

module gregorian_to_persian_date_unit
    import gtp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // gregorian_year, gregorian_month, gregorian_day
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // persian_year, persian_month, persian_day
    output logic [0:0]       m_axis_tuser    // bad_month
);

    logic   cnt_vld;
    logic   cyc_rdy;
    t_count cnt_data;
    logic   cyc_vld;
    logic   spl_rdy;
    t_cyc   cyc_data;

    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        out_bad;

    gtp_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_year  (s_axis_tdata[11:0]),
        .i_month (s_axis_tdata[15:12]),
        .i_day   (s_axis_tdata[20:16]),
        .o_vld   (cnt_vld),
        .i_rdy   (cyc_rdy),
        .o_data  (cnt_data)
    );

    gtp_cycle u_cycle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cnt_vld),
        .o_rdy   (cyc_rdy),
        .i_data  (cnt_data),
        .o_vld   (cyc_vld),
        .i_rdy   (spl_rdy),
        .o_data  (cyc_data)
    );

    gtp_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cyc_vld),
        .o_rdy   (spl_rdy),
        .i_data  (cyc_data),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_year  (out_year),
        .o_month (out_month),
        .o_day   (out_day),
        .o_bad   (out_bad)
    );

    assign m_axis_tdata = {3'b000, out_day, out_month, out_year};
    assign m_axis_tuser = out_bad;

    `GTP_ASSERT_PROP(a_bad_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0), "bad month result carries nonzero fields")

    `GTP_ASSERT_PROP(a_good_range, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[15:12] >= 4'd1 && m_axis_tdata[15:12] <= 4'd12 && m_axis_tdata[20:16] != 5'd0 && m_axis_tdata[23:21] == 3'd0), "result month or day out of range")

    `GTP_ASSERT_NEVER(a_no_idle_stall, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready), "input stalled while the output side is free")

endmodule

`default_nettype wire
